@@ src/assert_macros.svh @@
// Concurrent assertion helpers for the RTL files; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed")
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed")
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ src/bvcma_pkg.sv @@
`default_nettype none

package bvcma_pkg;

    localparam int MV_W      = 12;
    localparam int VAVG_W    = 9;
    localparam int CMAG_W    = 12;
    localparam int CAVG_W    = 15;
    localparam int GAIN_W    = 4;
    localparam int OFFSET_W  = 12;

    localparam int VAVG_MAX  = 454;
    localparam int CMAG_MAX  = 4095;

    localparam int WINDOW_DEF = 20;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd2500;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 4'd5;

    localparam logic [CAVG_W-1:0] CAVG_SAT = 15'h7FFF;

    // Voltage scaling by 1000/9014, reduced to 500/4507, as a reciprocal multiply.
    localparam int    VSCALE_SHIFT  = 25;
    localparam longint VSCALE_MULT_L =
        ((longint'(1) << VSCALE_SHIFT) * 500 + 4506) / 4507;
    localparam int    VSCALE_MULT_W = 22;
    localparam logic [VSCALE_MULT_W-1:0] VSCALE_MULT = VSCALE_MULT_W'(VSCALE_MULT_L);
    localparam int    VSCALE_PROD_W = MV_W + VSCALE_MULT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CFG_OFFSET = 1'b0,
        CFG_GAIN   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [VAVG_W-1:0] volt;
        logic              vok;
        logic [CMAG_W-1:0] cmag;
        logic              cok;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

endpackage

`default_nettype wire

@@ src/bvcma_front.sv @@
`default_nettype none

module bvcma_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [bvcma_pkg::OFFSET_W-1:0]   i_offset,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [bvcma_pkg::MV_W-1:0]       i_voltage_mv,
    input  wire logic                             i_voltage_ok,
    input  wire logic [bvcma_pkg::MV_W-1:0]       i_current_mv,
    input  wire logic                             i_current_ok,
    input  wire bvcma_pkg::t_queue_status         i_q_stat,
    output logic                                  o_push,
    output bvcma_pkg::t_item                      o_item
);
    import bvcma_pkg::*;

    logic                     r_vld;
    t_item                    r_item;
    logic [VSCALE_PROD_W-1:0] vprod;
    logic [CMAG_W-1:0]        cmag;

    assign vprod = VSCALE_PROD_W'(i_voltage_mv) * VSCALE_PROD_W'(VSCALE_MULT);
    assign cmag  = (i_current_mv >= i_offset) ? (i_current_mv - i_offset)
                                              : (i_offset - i_current_mv);

    assign o_push  = r_vld && !i_q_stat.full;
    assign o_ready = !r_vld || !i_q_stat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.volt <= vprod[VSCALE_SHIFT +: VAVG_W];
            r_item.vok  <= i_voltage_ok;
            r_item.cmag <= cmag;
            r_item.cok  <= i_current_ok;
        end
    end

endmodule

`default_nettype wire

@@ src/bvcma_queue.sv @@
`default_nettype none

module bvcma_queue (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire bvcma_pkg::t_item          i_item,
    input  wire logic                      i_pop,
    output bvcma_pkg::t_item               o_item,
    output bvcma_pkg::t_queue_status       o_stat
);
    import bvcma_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_item       = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/bvcma_back.sv @@
`default_nettype none

module bvcma_back #(
    parameter int WINDOW = bvcma_pkg::WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bvcma_pkg::GAIN_W-1:0]    i_gain,
    input  wire bvcma_pkg::t_item                i_item,
    input  wire bvcma_pkg::t_queue_status        i_q_stat,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [bvcma_pkg::VAVG_W-1:0]         o_voltage_avg,
    output logic [bvcma_pkg::CAVG_W-1:0]         o_current_avg_scaled
);
    import bvcma_pkg::*;

    localparam int PTR_W     = $clog2(WINDOW);
    localparam int VTOT_W    = $clog2(WINDOW * VAVG_MAX + 1);
    localparam int CTOT_W    = $clog2(WINDOW * CMAG_MAX + 1);
    localparam int DIV_SHIFT = CTOT_W + $clog2(WINDOW);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PW        = DIV_SHIFT + CMAG_W;
    localparam int GP_W      = CMAG_W + GAIN_W;

    logic [VAVG_W-1:0] r_vring [WINDOW];
    logic [CMAG_W-1:0] r_cring [WINDOW];
    logic [VTOT_W-1:0] r_vtot;
    logic [CTOT_W-1:0] r_ctot;
    logic [PTR_W-1:0]  r_slot;
    logic              r_full;

    logic              r_a_vld;
    logic              r_a_emit;
    logic              r_a_vok;
    logic              r_a_cok;

    logic              r_b_vld;
    logic              r_b_emit;
    logic              r_b_vok;
    logic              r_b_cok;
    logic [PW-1:0]     r_b_vprod;
    logic [PW-1:0]     r_b_cprod;

    logic              r_o_vld;
    logic [VAVG_W-1:0] r_last_v;
    logic [CAVG_W-1:0] r_last_c;

    logic              en;
    logic              pop;
    logic              last;
    logic [CMAG_W-1:0] cmean;
    logic [GP_W-1:0]   gprod;
    logic [CAVG_W-1:0] csat;

    assign en    = !r_o_vld || i_ready;
    assign pop   = en && !i_q_stat.empty;
    assign o_pop = pop;
    assign last  = (r_slot == PTR_W'(WINDOW - 1));

    assign cmean = r_b_cprod[DIV_SHIFT +: CMAG_W];
    assign gprod = GP_W'(cmean) * GP_W'(i_gain);
    assign csat  = (gprod > GP_W'(CAVG_SAT)) ? CAVG_SAT : gprod[CAVG_W-1:0];

    assign o_valid              = r_o_vld;
    assign o_voltage_avg        = r_last_v;
    assign o_current_avg_scaled = r_last_c;

    // The rings rotate by one word per item; an invalid channel feeds its oldest word back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_vring[i] <= '0;
                r_cring[i] <= '0;
            end
            r_vtot <= '0;
            r_ctot <= '0;
            r_slot <= '0;
            r_full <= 1'b0;
        end else if (pop) begin
            for (int i = 1; i < WINDOW; i++) begin
                r_vring[i] <= r_vring[i-1];
                r_cring[i] <= r_cring[i-1];
            end
            r_vring[0] <= i_item.vok ? i_item.volt : r_vring[WINDOW-1];
            r_cring[0] <= i_item.cok ? i_item.cmag : r_cring[WINDOW-1];
            if (i_item.vok) begin
                r_vtot <= r_vtot - VTOT_W'(r_vring[WINDOW-1]) + VTOT_W'(i_item.volt);
            end
            if (i_item.cok) begin
                r_ctot <= r_ctot - CTOT_W'(r_cring[WINDOW-1]) + CTOT_W'(i_item.cmag);
            end
            r_slot <= last ? '0 : r_slot + 1'b1;
            if (last) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            r_last_v <= '0;
            r_last_c <= '0;
        end else if (en) begin
            r_a_vld <= pop;
            r_b_vld <= r_a_vld;
            r_o_vld <= r_b_vld && r_b_emit;
            if (r_b_vld && r_b_emit) begin
                if (r_b_vok) begin
                    r_last_v <= r_b_vprod[DIV_SHIFT +: VAVG_W];
                end
                if (r_b_cok) begin
                    r_last_c <= csat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_emit  <= r_full || last;
            r_a_vok   <= i_item.vok;
            r_a_cok   <= i_item.cok;
            r_b_emit  <= r_a_emit;
            r_b_vok   <= r_a_vok;
            r_b_cok   <= r_a_cok;
            r_b_vprod <= PW'(r_vtot) * PW'(DIV_MULT);
            r_b_cprod <= PW'(r_ctot) * PW'(DIV_MULT);
        end
    end

endmodule

`default_nettype wire

@@ src/bus_voltage_current_moving_average.sv @@
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tdata: voltage_mv[11:0], current_mv[23:12]; tuser: voltage_ok, current_ok
// m_axis    out        tdata: voltage_avg[8:0], current_avg_scaled[23:9]
// cfg       in         index 0 current_offset_mv, index 1 current_gain; data[11:0]
//
// One sample word is taken every cycle while the queue has room; the rings and running
// sums update once per word. When neither side stalls, a result passes through the
// front register, queue slot and two back stages ahead of the output register.
// Reset clears the rings, sums, pointer and held outputs at once; there is no clearing pass.
// A stalled output holds the back pipeline; the four-word queue keeps input open until it fills.
`default_nettype none
`include "assert_macros.svh"

module bus_voltage_current_moving_average #(
    parameter int WINDOW = bvcma_pkg::WINDOW_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Bits from the lowest up: voltage_mv, current_mv.
    input  wire logic [23:0]                      i_s_axis_tdata,
    // Bits from the lowest up: voltage_ok, current_ok.
    input  wire logic [1:0]                       i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // Bits from the lowest up: voltage_avg, current_avg_scaled.
    output logic [23:0]                           o_m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire bvcma_pkg::t_cfg_index            i_cfg_index,
    input  wire logic [bvcma_pkg::OFFSET_W-1:0]   i_cfg_data
);
    import bvcma_pkg::*;

    logic [OFFSET_W-1:0] r_offset;
    logic [GAIN_W-1:0]   r_gain;

    t_item               f_item;
    t_item               q_item;
    t_queue_status       q_stat;
    logic                q_push;
    logic                q_pop;
    logic [VAVG_W-1:0]   voltage_avg;
    logic [CAVG_W-1:0]   current_avg_scaled;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {current_avg_scaled, voltage_avg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET: r_offset <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default:    r_gain   <= r_gain;
            endcase
        end
    end

    bvcma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_offset     (r_offset),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_voltage_mv (i_s_axis_tdata[11:0]),
        .i_voltage_ok (i_s_axis_tuser[0]),
        .i_current_mv (i_s_axis_tdata[23:12]),
        .i_current_ok (i_s_axis_tuser[1]),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_item       (f_item)
    );

    bvcma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    bvcma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_gain               (r_gain),
        .i_item               (q_item),
        .i_q_stat             (q_stat),
        .o_pop                (q_pop),
        .o_valid              (o_m_axis_tvalid),
        .i_ready              (i_m_axis_tready),
        .o_voltage_avg        (voltage_avg),
        .o_current_avg_scaled (current_avg_scaled)
    );

    `ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(q_pop && q_stat.empty));
    `ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(q_push && q_stat.full));
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1);
    `ASSERT_NEXT(a_count_down, i_clk, i_rst_n, q_pop && !q_push, q_stat.count == $past(q_stat.count) - 1'b1);

endmodule

`default_nettype wire
